@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, held off in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, held off in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ospfdr_pkg.sv @@
// Shared types, codes and helper functions of the DR election block.
// No dependencies; used by the controller, datapath, top level and checker.
package ospfdr_pkg;

  // default neighbor table depth
  localparam int NEIGHBOR_SLOTS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY  = 2'd2;
  localparam logic [7:0] OWN_PRIORITY_RST = 8'd1;

  // request modes
  localparam logic [2:0] MODE_SLOT_WRITE  = 3'd0;
  localparam logic [2:0] MODE_IFACE_UP    = 3'd1;
  localparam logic [2:0] MODE_WAIT_TIMER  = 3'd2;
  localparam logic [2:0] MODE_BACKUP_SEEN = 3'd3;
  localparam logic [2:0] MODE_NBR_CHANGE  = 3'd4;

  // interface states
  localparam logic [2:0] IF_DOWN    = 3'd0;
  localparam logic [2:0] IF_WAITING = 3'd1;
  localparam logic [2:0] IF_DR      = 3'd2;
  localparam logic [2:0] IF_BDR     = 3'd3;
  localparam logic [2:0] IF_DROTHER = 3'd4;

  // slot flags: bit 0 valid, bit 1 two-way
  localparam logic [1:0] FLAGS_CLEAR     = 2'b00;
  localparam logic [1:0] FLAGS_VALID_2WY = 2'b11;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  slot;
    logic        nbr_valid;
    logic        nbr_two_way;
    logic [31:0] nbr_address;
    logic [31:0] nbr_router_id;
    logic [7:0]  nbr_priority;
    logic [31:0] nbr_declared_dr;
    logic [31:0] nbr_declared_bdr;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  iface_state;
    logic [31:0] dr_address;
    logic [31:0] bdr_address;
    logic        router_lsa_request;
    logic        network_lsa_request;
  } out_item_t;

  // one neighbor table entry, also the form of an election candidate
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] rid;
    logic [7:0]  prio;
    logic [31:0] dr;
    logic [31:0] bdr;
  } slot_entry_t;

  // running best pick of the election
  typedef struct packed {
    logic        have;
    logic [31:0] addr;
    logic [31:0] rid;
    logic [7:0]  prio;
  } best_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_elect;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_COMMIT
  } ctl_state_t;

  // candidate strictly better than the current pick (or no pick yet)
  function automatic logic beats(input logic [7:0] prio, input logic [31:0] rid,
                                 input best_t best);
    return !best.have || (prio > best.prio) || ((prio == best.prio) && (rid > best.rid));
  endfunction

  // request runs an election in the given interface state
  function automatic logic is_election(input logic [2:0] mode, input logic [2:0] st);
    return (((mode == MODE_WAIT_TIMER) || (mode == MODE_BACKUP_SEEN)) && (st == IF_WAITING))
        || ((mode == MODE_NBR_CHANGE)
            && ((st == IF_DR) || (st == IF_BDR) || (st == IF_DROTHER)));
  endfunction

endpackage

@@ design/ospfdr_ctrl.sv @@
// Controller of the DR election block: accept, scan and commit sequencing.
// Depends on ospfdr_pkg.
module ospfdr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ospfdr_pkg::dp_sts_t sts,
  output ospfdr_pkg::dp_cmd_t cmd
);
  import ospfdr_pkg::*;

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      CS_IDLE: begin
        // no request is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.start_elect ? CS_SCAN : CS_COMMIT;
        end
      end
      CS_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = CS_COMMIT;
        end
      end
      CS_COMMIT: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

@@ design/ospfdr_dp.sv @@
// Datapath of the DR election block: config, interface state, neighbor table,
// election trackers and output register. Depends on ospfdr_pkg.
module ospfdr_dp #(
  parameter int NEIGHBOR_SLOTS = ospfdr_pkg::NEIGHBOR_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ospfdr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ospfdr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  ospfdr_pkg::in_item_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ospfdr_pkg::out_item_t                out_data,
  input  ospfdr_pkg::dp_cmd_t                  cmd,
  output ospfdr_pkg::dp_sts_t                  sts
);
  import ospfdr_pkg::*;

  localparam int AW = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
  localparam int CW = $clog2(NEIGHBOR_SLOTS + 1);

  // configuration
  logic [31:0] own_rid_r, own_addr_r;
  logic [7:0]  own_prio_r;

  // interface state
  logic [2:0]  iface_state_r, iface_state_nxt;
  logic [31:0] cur_dr_r, cur_dr_nxt, cur_bdr_r, cur_bdr_nxt;

  // neighbor table
  logic [1:0]  flags_r [NEIGHBOR_SLOTS];
  slot_entry_t slot_mem_r [NEIGHBOR_SLOTS];
  slot_entry_t rd_entry_r;
  logic [1:0]  rd_flags_r;
  logic [AW-1:0] rd_addr, wr_idx;
  logic        slot_in_range, mem_we, flags_we;
  logic [1:0]  flags_wr;

  // request and scan
  in_item_t    item_r;
  logic [CW-1:0] cnt_r;
  best_t       best_d_r, best_b1_r, best_b2_r;
  slot_entry_t cand;
  logic        cand_ok, claim_dr, claim_bdr, upd_d, upd_b1, upd_b2;

  // election outcome
  logic        bdr_ok, dr_ok, run_elect;
  logic [31:0] new_dr, new_bdr;
  logic [2:0]  el_state;
  logic        el_nlsa;

  // result
  logic        acc, rlsa, nlsa;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_rid_r  <= '0;
      own_addr_r <= '0;
      own_prio_r <= OWN_PRIORITY_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROUTER_ID) own_rid_r  <= cfg_data;
      if (cfg_index == CFG_ADDRESS)   own_addr_r <= cfg_data;
      if (cfg_index == CFG_PRIORITY)  own_prio_r <= cfg_data[7:0];
    end
  end

  // status to the controller
  assign sts.start_elect = is_election(in_data.mode, iface_state_r);
  assign sts.scan_last   = (cnt_r == CW'(NEIGHBOR_SLOTS));
  assign sts.out_free    = !out_valid_r || out_ready;

  // table addressing
  assign rd_addr       = (cnt_r < CW'(NEIGHBOR_SLOTS)) ? AW'(cnt_r) : '0;
  assign wr_idx        = AW'(item_r.slot);
  assign slot_in_range = (32'(item_r.slot) < NEIGHBOR_SLOTS);
  assign flags_we      = cmd.commit && (item_r.mode == MODE_SLOT_WRITE) && slot_in_range;
  assign mem_we        = flags_we && item_r.nbr_valid;
  assign flags_wr      = item_r.nbr_valid ? {item_r.nbr_two_way, 1'b1} : FLAGS_CLEAR;

  // slot flags: cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
        flags_r[i] <= FLAGS_CLEAR;
      end
    end else if (flags_we) begin
      flags_r[wr_idx] <= flags_wr;
    end
  end

  // slot contents memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[wr_idx] <= '{addr: item_r.nbr_address, rid: item_r.nbr_router_id,
                              prio: item_r.nbr_priority, dr: item_r.nbr_declared_dr,
                              bdr: item_r.nbr_declared_bdr};
    end
    rd_entry_r <= slot_mem_r[rd_addr];
    rd_flags_r <= flags_r[rd_addr];
  end

  // request register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // candidate of this scan step: self first, then slots in order
  always_comb begin
    if (cnt_r == '0) begin
      cand.addr = own_addr_r;
      cand.rid  = own_rid_r;
      cand.prio = own_prio_r;
      cand.dr   = cur_dr_r;
      cand.bdr  = cur_bdr_r;
      cand_ok   = 1'b1;
    end else begin
      cand    = rd_entry_r;
      cand_ok = (rd_flags_r == FLAGS_VALID_2WY) && (rd_entry_r.prio != '0);
    end
  end

  assign claim_dr  = (cand.dr == cand.addr);
  assign claim_bdr = (cand.bdr == cand.addr);
  assign upd_d     = cand_ok && claim_dr && beats(cand.prio, cand.rid, best_d_r);
  assign upd_b2    = cand_ok && !claim_dr && beats(cand.prio, cand.rid, best_b2_r);
  assign upd_b1    = cand_ok && !claim_dr && claim_bdr && beats(cand.prio, cand.rid, best_b1_r);

  // scan counter and best picks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      best_d_r  <= '0;
      best_b1_r <= '0;
      best_b2_r <= '0;
    end else if (cmd.capture) begin
      cnt_r     <= '0;
      best_d_r  <= '0;
      best_b1_r <= '0;
      best_b2_r <= '0;
    end else if (cmd.scan_step) begin
      cnt_r <= cnt_r + CW'(1);
      if (upd_d)  best_d_r  <= '{have: 1'b1, addr: cand.addr, rid: cand.rid, prio: cand.prio};
      if (upd_b1) best_b1_r <= '{have: 1'b1, addr: cand.addr, rid: cand.rid, prio: cand.prio};
      if (upd_b2) best_b2_r <= '{have: 1'b1, addr: cand.addr, rid: cand.rid, prio: cand.prio};
    end
  end

  // election outcome from the finished picks
  always_comb begin
    bdr_ok  = best_b1_r.have || best_b2_r.have;
    new_bdr = best_b1_r.have ? best_b1_r.addr : (best_b2_r.have ? best_b2_r.addr : '0);
    dr_ok   = best_d_r.have || bdr_ok;
    new_dr  = best_d_r.have ? best_d_r.addr : new_bdr;
    el_nlsa = dr_ok && (new_dr == own_addr_r) && (cur_dr_r != own_addr_r);
    if (dr_ok && (own_addr_r == new_dr)) begin
      el_state = IF_DR;
    end else if (bdr_ok && (own_addr_r == new_bdr)) begin
      el_state = IF_BDR;
    end else begin
      el_state = IF_DROTHER;
    end
  end

  assign run_elect = is_election(item_r.mode, iface_state_r);

  // per-request state update and result
  always_comb begin
    iface_state_nxt = iface_state_r;
    cur_dr_nxt      = cur_dr_r;
    cur_bdr_nxt     = cur_bdr_r;
    acc             = 1'b0;
    rlsa            = 1'b0;
    nlsa            = 1'b0;
    case (item_r.mode)
      MODE_SLOT_WRITE: begin
        acc = slot_in_range;
      end
      MODE_IFACE_UP: begin
        if (iface_state_r == IF_DOWN) begin
          acc             = 1'b1;
          iface_state_nxt = IF_WAITING;
        end
      end
      default: begin
        if (run_elect) begin
          acc             = 1'b1;
          rlsa            = 1'b1;
          nlsa            = el_nlsa;
          iface_state_nxt = el_state;
          cur_dr_nxt      = new_dr;
          cur_bdr_nxt     = new_bdr;
        end
      end
    endcase
  end

  // interface state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iface_state_r <= IF_DOWN;
      cur_dr_r      <= '0;
      cur_bdr_r     <= '0;
    end else if (cmd.commit) begin
      iface_state_r <= iface_state_nxt;
      cur_dr_r      <= cur_dr_nxt;
      cur_bdr_r     <= cur_bdr_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.accepted            <= acc;
      out_data_r.iface_state         <= iface_state_nxt;
      out_data_r.dr_address          <= cur_dr_nxt;
      out_data_r.bdr_address         <= cur_bdr_nxt;
      out_data_r.router_lsa_request  <= rlsa;
      out_data_r.network_lsa_request <= nlsa;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/ospf_interface_dr_election.sv @@
// Top level of the OSPF interface DR election block.
// Depends on ospfdr_pkg, ospfdr_ctrl and ospfdr_dp.
//
//   port group  | direction | handshake          | payload
//   ------------+-----------+--------------------+--------------------------
//   in_*        | input     | in_valid/in_ready  | in_data (in_item_t)
//   out_*       | output    | out_valid/out_ready| out_data (out_item_t)
//   cfg_*       | input     | cfg_we             | cfg_index, cfg_data
//
// One request at a time. Slot writes, interface up and rejected requests pass
// through accept and commit; an election adds a scan between them that takes the
// own-router step first and then reads one table entry per cycle.
// Synchronous reset clears the slot flags at once; there is no clearing pass.
// A held result stalls the commit step only; the next request waits in front.
module ospf_interface_dr_election #(
  parameter int NEIGHBOR_SLOTS = ospfdr_pkg::NEIGHBOR_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ospfdr_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ospfdr_pkg::out_item_t             out_data,
  input  logic                              cfg_we,
  input  logic [ospfdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ospfdr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ospfdr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  ospfdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, election and result
  ospfdr_dp #(
    .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ design/ospfdr_checker.sv @@
// Port-level checks of the DR election block, bound to the top level.
// Depends on ospfdr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ospfdr_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input ospfdr_pkg::out_item_t out_data
);
  import ospfdr_pkg::*;

  // a network LSA request only comes with an accepted election that made us DR
  `ASSERT_IMPLIES(a_nlsa_dr, clk, rst_n, out_valid && out_data.network_lsa_request, out_data.router_lsa_request && out_data.iface_state == IF_DR, "network LSA request without becoming DR")

  // an election always leaves DR, BDR or DR-other
  `ASSERT_IMPLIES(a_elect_state, clk, rst_n, out_valid && out_data.router_lsa_request, out_data.accepted && (out_data.iface_state == IF_DR || out_data.iface_state == IF_BDR || out_data.iface_state == IF_DROTHER), "election result in a non-elected state")

  // a rejected request raises no LSA request
  `ASSERT_IMPLIES(a_reject_quiet, clk, rst_n, out_valid && !out_data.accepted, !out_data.router_lsa_request && !out_data.network_lsa_request, "rejected request raised an LSA request")

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind ospf_interface_dr_election ospfdr_checker u_ospfdr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ sim/ospf_interface_dr_election_test.sv @@
// Self-checking testbench for the OSPF interface DR election block.
// Depends on ospfdr_pkg and ospf_interface_dr_election from the design folder.
module ospf_interface_dr_election_test;
  import ospfdr_pkg::*;

  localparam int SLOTS          = NEIGHBOR_SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = SLOTS + 8;
  localparam int SEGMENT_ITEMS  = 240;
  localparam int SEGMENTS       = 6;
  localparam int RESET_CYCLES   = 11;

  // mode codes the block does not define
  localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
  localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;

  // one neighbor table entry as the predictor keeps it
  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] rid;
    logic [7:0]  prio;
    logic [31:0] dr;
    logic [31:0] bdr;
  } nbr_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROUTER_ID;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  ospf_interface_dr_election #(
    .NEIGHBOR_SLOTS(SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // predictor copy of configuration and state
  logic [31:0] my_router_id = '0;
  logic [31:0] my_address   = '0;
  logic [7:0]  my_priority  = OWN_PRIORITY_RST;
  logic [2:0]  if_state     = IF_DOWN;
  logic [31:0] dr_addr      = '0;
  logic [31:0] bdr_addr     = '0;
  logic        tbl_valid    [SLOTS];
  logic        tbl_two_way  [SLOTS];
  nbr_t        tbl_entry    [SLOTS];

  in_item_t  pending_requests [$];
  out_item_t expected_status  [$];
  out_item_t head_status;

  logic in_taken      = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   idle_cycles   = 0;
  int   error_count   = 0;
  int   request_count = 0;
  int   reject_count  = 0;
  int   elect_count   = 0;
  int   dr_gain_count = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i]   = 1'b0;
      tbl_two_way[i] = 1'b0;
      tbl_entry[i]   = '0;
    end
  end

  // append a request to the driver queue
  task automatic queue_request(in_item_t req);
    pending_requests = {pending_requests, req};
  endtask

  // strict ordering: priority, then router id
  function automatic logic outranks(nbr_t a, nbr_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    return a.rid > b.rid;
  endfunction

  // election over self and eligible neighbors; returns 1 when we newly became DR
  function automatic logic elect_dr_bdr();
    nbr_t        c;
    nbr_t        best_b1;
    nbr_t        best_b2;
    nbr_t        best_d;
    logic        have_b1;
    logic        have_b2;
    logic        have_d;
    logic        dr_ok;
    logic        bdr_ok;
    logic        gained;
    logic [31:0] new_dr;
    logic [31:0] new_bdr;
    int          i;
    best_b1 = '0; best_b2 = '0; best_d = '0;
    have_b1 = 1'b0; have_b2 = 1'b0; have_d = 1'b0;
    dr_ok = 1'b0; bdr_ok = 1'b0; gained = 1'b0;
    new_dr = '0; new_bdr = '0;
    for (i = -1; i < SLOTS; i++) begin
      if (i < 0) begin
        c = '{my_address, my_router_id, my_priority, dr_addr, bdr_addr};
      end else begin
        if (!(tbl_valid[i] && tbl_two_way[i]) || tbl_entry[i].prio == 8'd0) continue;
        c = tbl_entry[i];
      end
      if (c.dr == c.addr) begin
        if (!have_d || outranks(c, best_d)) begin
          best_d = c; have_d = 1'b1;
        end
      end else begin
        if (!have_b2 || outranks(c, best_b2)) begin
          best_b2 = c; have_b2 = 1'b1;
        end
        if (c.bdr == c.addr && (!have_b1 || outranks(c, best_b1))) begin
          best_b1 = c; have_b1 = 1'b1;
        end
      end
    end
    if (have_b1) begin
      new_bdr = best_b1.addr; bdr_ok = 1'b1;
    end else if (have_b2) begin
      new_bdr = best_b2.addr; bdr_ok = 1'b1;
    end
    if (have_d) begin
      new_dr = best_d.addr; dr_ok = 1'b1;
    end else if (bdr_ok) begin
      new_dr = new_bdr; dr_ok = 1'b1;
    end
    gained = dr_ok && new_dr == my_address && dr_addr != my_address;
    dr_addr  = new_dr;
    bdr_addr = new_bdr;
    if (dr_ok && my_address == new_dr) if_state = IF_DR;
    else if (bdr_ok && my_address == new_bdr) if_state = IF_BDR;
    else if_state = IF_DROTHER;
    return gained;
  endfunction

  // expected status for one accepted request; advances the predictor state
  function automatic out_item_t predict_dr_election(in_item_t req);
    out_item_t res;
    res = '0;
    case (req.mode)
      MODE_SLOT_WRITE: begin
        if (int'(req.slot) < SLOTS) begin
          res.accepted = 1'b1;
          if (req.nbr_valid) begin
            tbl_valid[req.slot]   = 1'b1;
            tbl_two_way[req.slot] = req.nbr_two_way;
            tbl_entry[req.slot]   = '{req.nbr_address, req.nbr_router_id, req.nbr_priority,
                                      req.nbr_declared_dr, req.nbr_declared_bdr};
          end else begin
            tbl_valid[req.slot]   = 1'b0;
            tbl_two_way[req.slot] = 1'b0;
          end
        end
      end
      MODE_IFACE_UP: begin
        if (if_state == IF_DOWN) begin
          if_state = IF_WAITING;
          res.accepted = 1'b1;
        end
      end
      MODE_WAIT_TIMER, MODE_BACKUP_SEEN: begin
        if (if_state == IF_WAITING) begin
          res.accepted = 1'b1;
          res.network_lsa_request = elect_dr_bdr();
          res.router_lsa_request = 1'b1;
        end
      end
      MODE_NBR_CHANGE: begin
        if (if_state == IF_DR || if_state == IF_BDR || if_state == IF_DROTHER) begin
          res.accepted = 1'b1;
          res.network_lsa_request = elect_dr_bdr();
          res.router_lsa_request = 1'b1;
        end
      end
      default: ;
    endcase
    res.iface_state = if_state;
    res.dr_address  = dr_addr;
    res.bdr_address = bdr_addr;
    return res;
  endfunction

  // value pools that make claims, ties and self matches likely
  function automatic logic [31:0] pick_address();
    case ($urandom_range(7))
      0: return my_address;
      1: return 32'h0;
      2: return 32'hFFFF_FFFF;
      3, 4, 5: return 32'h0A00_0000 + $urandom_range(1, 4);
      6: return 32'hC0A8_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_router_id();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return my_router_id;
      3, 4: return $urandom_range(1, 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_priority();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      3: return my_priority;
      4: return 8'($urandom_range(1, 3));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // request of the given mode with a fully random payload
  function automatic in_item_t make_event(logic [2:0] mode);
    in_item_t req;
    req.mode             = mode;
    req.slot             = 4'($urandom_range(15));
    req.nbr_valid        = 1'($urandom_range(1));
    req.nbr_two_way      = 1'($urandom_range(1));
    req.nbr_address      = $urandom;
    req.nbr_router_id    = $urandom;
    req.nbr_priority     = 8'($urandom_range(255));
    req.nbr_declared_dr  = $urandom;
    req.nbr_declared_bdr = $urandom;
    return req;
  endfunction

  function automatic in_item_t make_slot_write(int slot, logic valid, logic two_way,
                                               logic [31:0] addr, logic [31:0] rid,
                                               logic [7:0] prio, logic [31:0] dr,
                                               logic [31:0] bdr);
    in_item_t req;
    req = '{MODE_SLOT_WRITE, 4'(slot), valid, two_way, addr, rid, prio, dr, bdr};
    return req;
  endfunction

  // neighbor update drawn from the pools, often claiming DR or BDR
  function automatic in_item_t random_slot_write();
    logic [31:0] addr;
    logic [31:0] dr;
    logic [31:0] bdr;
    addr = pick_address();
    dr   = ($urandom_range(99) < 30) ? addr : pick_address();
    bdr  = ($urandom_range(99) < 35) ? addr : pick_address();
    return make_slot_write($urandom_range(SLOTS - 1), 1'b1, $urandom_range(99) < 85,
                           addr, pick_router_id(), pick_priority(), dr, bdr);
  endfunction

  function automatic in_item_t random_request();
    int r;
    in_item_t req;
    r = $urandom_range(99);
    if (r < 45) begin
      req = random_slot_write();
    end else if (r < 55) begin
      req = make_event(MODE_SLOT_WRITE);
      req.nbr_valid = 1'b0;
    end else if (r < 85) begin
      req = make_event(MODE_NBR_CHANGE);
    end else if (r < 89) begin
      req = make_event($urandom_range(1) ? MODE_WAIT_TIMER : MODE_BACKUP_SEEN);
    end else if (r < 92) begin
      req = make_event(MODE_IFACE_UP);
    end else begin
      req = make_event(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)));
    end
    return req;
  endfunction

  // writes all three own-router registers back to back; block must be idle
  task automatic write_own_config(logic [31:0] rid, logic [31:0] addr, logic [7:0] prio);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROUTER_ID;
    cfg_data  <= rid;
    @(negedge clk);
    cfg_index <= CFG_ADDRESS;
    cfg_data  <= addr;
    @(negedge clk);
    cfg_index <= CFG_PRIORITY;
    cfg_data  <= CFG_DATA_W'(prio);
    @(negedge clk);
    cfg_we    <= 1'b0;
    my_router_id = rid;
    my_address   = addr;
    my_priority  = prio;
  endtask

  // wait until every request is taken and answered, then let the block settle
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_status.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // request driver: next pending request or idle, at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: check results, predict accepted requests, watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken    <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $error("result with no request outstanding: %h", out_data);
          error_count++;
        end else begin
          head_status = expected_status.pop_front();
          check_field("accepted", head_status.accepted, out_data.accepted);
          check_field("iface_state", head_status.iface_state, out_data.iface_state);
          check_field("dr_address", head_status.dr_address, out_data.dr_address);
          check_field("bdr_address", head_status.bdr_address, out_data.bdr_address);
          check_field("router_lsa_request", head_status.router_lsa_request,
                      out_data.router_lsa_request);
          check_field("network_lsa_request", head_status.network_lsa_request,
                      out_data.network_lsa_request);
        end
      end
      if (in_valid && in_ready) begin
        head_status = predict_dr_election(in_data);
        expected_status = {expected_status, head_status};
        request_count++;
        if (!head_status.accepted) reject_count++;
        if (head_status.router_lsa_request) elect_count++;
        if (head_status.network_lsa_request) dr_gain_count++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // stimulus and run control
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 26;
    recv_idle_pct = 80;

    // directed: rejects while down, table edge cases, bring-up, first election
    queue_request(make_event(MODE_NBR_CHANGE));
    queue_request(make_event(MODE_WAIT_TIMER));
    queue_request(make_event(MODE_BACKUP_SEEN));
    queue_request(make_event(MODE_UNUSED_LO));
    queue_request(make_event(MODE_UNUSED_MID));
    queue_request(make_event(MODE_UNUSED_HI));
    queue_request(make_slot_write(0, 1'b1, 1'b1, 32'h0A00_0001, 32'hFFFF_FFFF,
                                  8'd255, 32'h0A00_0001, 32'h0));
    queue_request(make_slot_write(SLOTS - 1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0,
                                  8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_request(make_slot_write(1, 1'b1, 1'b0, 32'h0A00_0003, 32'd9,
                                  8'd200, 32'h0, 32'h0A00_0003));
    // equal priority and id, both claiming BDR: lower slot must win
    queue_request(make_slot_write(2, 1'b1, 1'b1, 32'h0A00_0002, 32'd5,
                                  8'd1, 32'h0, 32'h0A00_0002));
    queue_request(make_slot_write(3, 1'b1, 1'b1, 32'h0A00_0004, 32'd5,
                                  8'd1, 32'h0, 32'h0A00_0004));
    queue_request(make_event(MODE_IFACE_UP));
    queue_request(make_event(MODE_IFACE_UP));
    queue_request(make_event(MODE_NBR_CHANGE));
    queue_request(make_event(MODE_BACKUP_SEEN));
    queue_request(make_event(MODE_WAIT_TIMER));
    // clear keeps contents, then rerun; then strip the table down to self
    queue_request(make_slot_write(0, 1'b0, 1'b0, '1, '1, '1, '1, '1));
    queue_request(make_event(MODE_NBR_CHANGE));
    for (int s = 1; s < 4; s++)
      queue_request(make_slot_write(s, 1'b0, 1'b1, '0, '0, '0, '0, '0));
    queue_request(make_event(MODE_NBR_CHANGE));
    queue_request(make_event(MODE_NBR_CHANGE));
    wait_idle();

    // random segments, each with its own register setting; each pair of segments shares an idle pattern
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin send_idle_pct = 26; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (seg)
        0: write_own_config(32'hFFFF_FFFF, 32'h0A00_0004, 8'd255);
        1: write_own_config(32'h0, 32'h0, 8'd0);
        2: write_own_config($urandom, 32'hFFFF_FFFF, 8'($urandom_range(1, 254)));
        3: write_own_config(32'hFFFF_FFFF, 32'hC0A8_0001, 8'd1);
        4: write_own_config($urandom, $urandom, 8'($urandom_range(255)));
        default: write_own_config(32'h0, 32'h0A00_0001, 8'd255);
      endcase
      for (int n = 0; n < SEGMENT_ITEMS; n++)
        queue_request(random_request());
      wait_idle();
    end

    if (expected_status.size() != 0) begin
      $error("%0d results never arrived", expected_status.size());
      error_count++;
    end
    $display("Run covered %0d requests: %0d rejected, %0d elections, %0d DR takeovers",
             request_count, reject_count, elect_count, dr_gain_count);
    $display("Six register settings under three idle patterns; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/ospfdr_pkg.sv
design/ospfdr_ctrl.sv
design/ospfdr_dp.sv
design/ospf_interface_dr_election.sv
design/ospfdr_checker.sv
sim/ospf_interface_dr_election_test.sv
